>>> rtl/core/adc_window_average_altitude_macros.svh
// assertion macros used by the port checker of the windowed altitude average
`ifndef ADC_WINDOW_AVERAGE_ALTITUDE_MACROS_SVH
`define ADC_WINDOW_AVERAGE_ALTITUDE_MACROS_SVH

// expects signals named clock and reset in the scope of use
`define AWA_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("port check failed");

`define AWA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

>>> rtl/core/awa_pkg.sv
// shared constants, derived widths and types of the windowed altitude average
package awa_pkg;

   // block constants
   localparam int DEPTH       = 20;
   localparam int SAMPLE_BITS = 12;
   localparam int SPAN_COUNTS = 1241;
   localparam int PCT_SCALE   = 100;

   // fixed field widths
   localparam int SAMPLE_W = 12;
   localparam int MEAN_W   = 12;
   localparam int TOP_W    = 13;
   localparam int PCT_W    = 10;

   // sample mask, limited by the port width
   localparam int SAMPLE_MAX = (SAMPLE_BITS < SAMPLE_W) ? (1 << SAMPLE_BITS) - 1
                                                         : (1 << SAMPLE_W) - 1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'(SAMPLE_MAX);

   // window ring and running sum
   localparam int POS_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_MAX = DEPTH * SAMPLE_MAX;
   localparam int SUM_W   = $clog2(SUM_MAX + 1);

   // rounded mean: (2*sum + DEPTH) / (2*DEPTH) by reciprocal multiply
   localparam int    MEAN_DIV = 2 * DEPTH;
   localparam int    NUM_MAX  = 2 * SUM_MAX + DEPTH;
   localparam int    NUM_W    = $clog2(NUM_MAX + 1);
   localparam int    MEAN_SH  = NUM_W + $clog2(MEAN_DIV);
   localparam longint MEAN_REC = ((longint'(1) << MEAN_SH) + MEAN_DIV - 1) / MEAN_DIV;
   localparam int    MREC_W   = $clog2(MEAN_REC + 1);
   localparam logic [MREC_W-1:0] MEAN_REC_V = MREC_W'(MEAN_REC);
   localparam int    PROD1_W  = (NUM_W + MREC_W > MEAN_SH + MEAN_W) ? NUM_W + MREC_W
                                                                     : MEAN_SH + MEAN_W;

   // percent: |ground - mean| * 100 / SPAN_COUNTS by reciprocal multiply
   localparam int    MAG_MAX  = ((1 << MEAN_W) - 1) * PCT_SCALE;
   localparam int    MAG_W    = $clog2(MAG_MAX + 1);
   localparam int    PCT_SH   = MAG_W + $clog2(SPAN_COUNTS);
   localparam longint PCT_REC = ((longint'(1) << PCT_SH) + SPAN_COUNTS - 1) / SPAN_COUNTS;
   localparam int    PREC_W   = $clog2(PCT_REC + 1);
   localparam logic [PREC_W-1:0] PCT_REC_V = PREC_W'(PCT_REC);
   localparam int    PROD2_W  = (MAG_W + PREC_W > PCT_SH + MAG_W) ? MAG_W + PREC_W
                                                                  : PCT_SH + MAG_W;
   localparam int    PCT_POS_LIM = (1 << (PCT_W - 1)) - 1;
   localparam int    PCT_NEG_LIM = 1 << (PCT_W - 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             capture;
   } awa_entry_type;

   typedef struct packed {
      logic          valid;
      awa_entry_type entry;
   } awa_push_type;

endpackage

>>> rtl/core/awa_front.sv
// front end: takes sample beats, updates the window ring and running sum
module awa_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [awa_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                            req_capture_ground,
   input  logic                            q_full,
   output awa_pkg::awa_push_type           push
);
   import awa_pkg::*;

   logic [SAMPLE_W-1:0] window_ff [DEPTH];
   logic [POS_W-1:0]    wpos_ff, wpos_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] sample_m;
   logic                accept;

   always_comb begin
      accept   = req_valid && !q_full;
      sample_m = req_sample & SAMPLE_MASK;
      // oldest slot drops out, new sample comes in
      sum_in   = sum_ff - SUM_W'(window_ff[wpos_ff]) + SUM_W'(sample_m);
      wpos_in  = (wpos_ff == POS_W'(DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
      push.valid         = accept;
      push.entry.sum     = sum_in;
      push.entry.capture = req_capture_ground;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         wpos_ff <= '0;
         sum_ff  <= '0;
      end else if (accept) begin
         window_ff[wpos_ff] <= sample_m;
         wpos_ff            <= wpos_in;
         sum_ff             <= sum_in;
      end
   end

endmodule

>>> rtl/core/awa_queue.sv
// short fifo of running sums between front and back
module awa_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  awa_pkg::awa_push_type    push,
   input  logic                     pop,
   output logic                     full,
   output logic                     pop_valid,
   output awa_pkg::awa_entry_type   pop_entry
);
   import awa_pkg::*;

   awa_entry_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      pop_valid = (count_ff != '0);
      pop_entry = entries_ff[rd_ptr_ff];
      do_push   = push.valid && !full;
      do_pop    = pop && pop_valid;
      wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

>>> rtl/core/awa_back.sv
// back end: mean, ground capture, top and percent in a four-stage pipeline
module awa_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  awa_pkg::awa_entry_type              q_entry,
   output logic                                q_pop,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [awa_pkg::MEAN_W-1:0]          rsp_mean,
   output logic [awa_pkg::MEAN_W-1:0]          rsp_ground,
   output logic signed [awa_pkg::TOP_W-1:0]    rsp_top,
   output logic signed [awa_pkg::PCT_W-1:0]    rsp_percent
);
   import awa_pkg::*;

   logic advance;

   // stage 1: mean reciprocal product
   logic               s1_valid_ff;
   logic               s1_cap_ff;
   logic [PROD1_W-1:0] s1_prod_ff;
   logic [NUM_W-1:0]   num;

   // stage 2: ground update and scaled magnitude
   logic               s2_valid_ff;
   logic [MEAN_W-1:0]  s2_mean_ff, s2_ground_ff;
   logic               s2_neg_ff;
   logic [MAG_W-1:0]   s2_mag_ff;
   logic [MEAN_W-1:0]  ground_ff, ground_in;
   logic [MEAN_W-1:0]  mean_w;
   logic [MEAN_W:0]    diff;
   logic [MEAN_W-1:0]  mag;

   // stage 3: percent reciprocal product
   logic               s3_valid_ff;
   logic [MEAN_W-1:0]  s3_mean_ff, s3_ground_ff;
   logic               s3_neg_ff;
   logic [PROD2_W-1:0] s3_prod_ff;

   // output stage
   logic                    rsp_valid_ff;
   logic [MEAN_W-1:0]       rsp_mean_ff, rsp_ground_ff;
   logic signed [TOP_W-1:0] rsp_top_ff, top_in;
   logic signed [PCT_W-1:0] rsp_pct_ff, pct_in;
   logic [MAG_W-1:0]        quot;

   always_comb begin
      advance = !rsp_valid_ff || !rsp_stall;
      q_pop   = advance;
      num     = NUM_W'({q_entry.sum, 1'b0}) + NUM_W'(DEPTH);

      mean_w    = s1_prod_ff[MEAN_SH +: MEAN_W];
      ground_in = s1_cap_ff ? mean_w : ground_ff;
      diff      = {1'b0, ground_in} - {1'b0, mean_w};
      mag       = diff[MEAN_W] ? MEAN_W'(-diff) : diff[MEAN_W-1:0];

      quot   = s3_prod_ff[PCT_SH +: MAG_W];
      top_in = TOP_W'({1'b0, s3_ground_ff}) - TOP_W'(SPAN_COUNTS);
      priority if (s3_neg_ff && quot > MAG_W'(PCT_NEG_LIM)) begin
         pct_in = PCT_W'(PCT_NEG_LIM);
      end else if (s3_neg_ff) begin
         pct_in = -PCT_W'(quot);
      end else if (quot > MAG_W'(PCT_POS_LIM)) begin
         pct_in = PCT_W'(PCT_POS_LIM);
      end else begin
         pct_in = PCT_W'(quot);
      end

      rsp_valid   = rsp_valid_ff;
      rsp_mean    = rsp_mean_ff;
      rsp_ground  = rsp_ground_ff;
      rsp_top     = rsp_top_ff;
      rsp_percent = rsp_pct_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ground_ff    <= '0;
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
         if (s1_valid_ff) begin
            ground_ff <= ground_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cap_ff     <= q_entry.capture;
         s1_prod_ff    <= PROD1_W'(num) * PROD1_W'(MEAN_REC_V);
         s2_mean_ff    <= mean_w;
         s2_ground_ff  <= ground_in;
         s2_neg_ff     <= diff[MEAN_W];
         s2_mag_ff     <= MAG_W'(mag) * MAG_W'(PCT_SCALE);
         s3_mean_ff    <= s2_mean_ff;
         s3_ground_ff  <= s2_ground_ff;
         s3_neg_ff     <= s2_neg_ff;
         s3_prod_ff    <= PROD2_W'(s2_mag_ff) * PROD2_W'(PCT_REC_V);
         rsp_mean_ff   <= s3_mean_ff;
         rsp_ground_ff <= s3_ground_ff;
         rsp_top_ff    <= top_in;
         rsp_pct_ff    <= pct_in;
      end
   end

endmodule

>>> rtl/core/adc_window_average_altitude.sv
// top level of the windowed altitude average: front, queue and back wired up
// Each req beat carries one converter sample; it goes into a ring of the last
// twenty samples and the running sum of the ring moves by one add and one
// subtract, so the block takes one beat every clock cycle while the queue is
// not full. Every beat gives exactly one rsp beat: the rounded window mean,
// the ground reference (set to that mean when capture_ground is 1), the top
// reference and the altitude percentage. The back end is a four-stage
// pipeline with two constant reciprocal multiplies. A four-entry queue sits
// between the running-sum front end and the back end, so req beats keep
// flowing while a result is held by rsp_stall; req_stall rises only once that
// queue is full. Reset clears the ring, the sum and the ground reference at
// once, with no clearing pass: slots not yet filled count as zero, so the mean
// climbs while the ring fills.
module adc_window_average_altitude (
   input  logic                                clock,
   input  logic                                reset,
   // sample beats
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [awa_pkg::SAMPLE_W-1:0]        req_sample,
   input  logic                                req_capture_ground,
   // result beats
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [awa_pkg::MEAN_W-1:0]          rsp_mean,
   output logic [awa_pkg::MEAN_W-1:0]          rsp_ground,
   output logic signed [awa_pkg::TOP_W-1:0]    rsp_top,
   output logic signed [awa_pkg::PCT_W-1:0]    rsp_percent
);
   import awa_pkg::*;

   // front to queue
   awa_push_type  push;
   logic          q_full;
   // queue to back
   logic          q_valid;
   logic          q_pop;
   awa_entry_type q_entry;

   // backpressure on req only from a full queue
   assign req_stall = q_full;

   // ring, running sum and beat acceptance
   awa_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_sample         (req_sample),
      .req_capture_ground (req_capture_ground),
      .q_full             (q_full),
      .push               (push)
   );

   // decoupling queue: holds updated sums and capture flags
   awa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (q_pop),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_entry (q_entry)
   );

   // mean, ground capture, top and percent, then the output register
   awa_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_mean    (rsp_mean),
      .rsp_ground  (rsp_ground),
      .rsp_top     (rsp_top),
      .rsp_percent (rsp_percent)
   );

endmodule

>>> rtl/core/awa_checker.sv
// port checker for the windowed altitude average and its bind
`include "adc_window_average_altitude_macros.svh"

module awa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [awa_pkg::MEAN_W-1:0]          rsp_mean,
   input logic [awa_pkg::MEAN_W-1:0]          rsp_ground,
   input logic signed [awa_pkg::TOP_W-1:0]    rsp_top,
   input logic signed [awa_pkg::PCT_W-1:0]    rsp_percent
);
   import awa_pkg::*;

   logic [MEAN_W-1:0]                    last_ground_ff;
   logic [2*MEAN_W+TOP_W+PCT_W-1:0]      rsp_word;
   logic [TOP_W-1:0]                     top_plus_span;
   logic                                 ground_low, ground_high, pct_neg, pct_zero;

   // whole result beat, top shifted back by the span, and sign terms
   always_comb begin
      rsp_word      = {rsp_mean, rsp_ground, rsp_top, rsp_percent};
      top_plus_span = rsp_top + TOP_W'(SPAN_COUNTS);
      ground_low    = rsp_ground < rsp_mean;
      ground_high   = rsp_ground > rsp_mean;
      pct_neg       = rsp_percent[PCT_W-1];
      pct_zero      = (rsp_percent == '0);
   end

   // ground of the last delivered result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ground_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         last_ground_ff <= rsp_ground;
      end
   end

   `AWA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `AWA_ASSERT_IMPLIES(a_top_ref, rsp_valid, top_plus_span == {1'b0, rsp_ground})
   `AWA_ASSERT_IMPLIES(a_ground_source, rsp_valid && !rsp_stall, rsp_ground == last_ground_ff || rsp_ground == rsp_mean)
   `AWA_ASSERT_IMPLIES(a_percent_sign, rsp_valid, (ground_low || !pct_neg) && (ground_high || pct_neg || pct_zero))

endmodule

bind adc_window_average_altitude awa_checker u_awa_checker (.*);

>>> bench/adc_window_average_altitude_tb.sv
// self-checking bench of the windowed altitude average, table-driven then random sample beats
module adc_window_average_altitude_tb;

   import awa_pkg::*;

   // one result beat as the block presents it
   typedef struct packed {
      logic [MEAN_W-1:0]        mean;
      logic [MEAN_W-1:0]        ground;
      logic signed [TOP_W-1:0]  top;
      logic signed [PCT_W-1:0]  percent;
   } altitude_reading_type;

   // one row of the directed table: a sample repeated a number of times, with
   // the reading typed in where it is obvious, otherwise left to the predictor
   typedef struct packed {
      logic [SAMPLE_W-1:0]  sample;
      logic                 capture;
      logic [7:0]           repeats;
      logic                 fixed;
      altitude_reading_type reading;
   } stim_row_type;

   localparam int QUIET_LIMIT   = 2000;
   localparam int DIRECTED_ROWS = 7;
   localparam int FULL_SCALE    = (1 << SAMPLE_W) - 1;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // fresh ring is all zero, so capturing now pins ground at zero
      '{12'd0,    1'b1, 8'd1,  1'b1, '{12'd0,    12'd0,    -13'sd1241, 10'sd0}},
      // ring fills with full scale, the mean climbs towards it
      '{12'd4095, 1'b0, 8'd19, 1'b0, '0},
      // last zero slot overwritten: full-scale mean over a zero ground
      '{12'd4095, 1'b0, 8'd1,  1'b1, '{12'd4095, 12'd0,    -13'sd1241, -10'sd329}},
      // capture at full scale gives the highest top reference
      '{12'd4095, 1'b1, 8'd1,  1'b1, '{12'd4095, 12'd4095, 13'sd2854,  10'sd0}},
      // mean starts to fall below ground, percent turns positive
      '{12'd0,    1'b0, 8'd2,  1'b0, '0},
      '{12'hAAA,  1'b0, 8'd1,  1'b0, '0},
      '{12'h555,  1'b1, 8'd1,  1'b0, '0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_W-1:0]       req_sample = '0;
   logic                      req_capture_ground = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [MEAN_W-1:0]         rsp_mean;
   logic [MEAN_W-1:0]         rsp_ground;
   logic signed [TOP_W-1:0]   rsp_top;
   logic signed [PCT_W-1:0]   rsp_percent;

   // travels with the req beat: use the typed reading instead of the predicted one
   logic                      beat_fixed = 1'b0;
   altitude_reading_type      beat_fixed_reading = '0;

   // predictor state: the sample ring, its running sum and the ground reference
   logic [SAMPLE_W-1:0]       ring_samples [DEPTH];
   int                        ring_pos;
   int                        ring_sum;
   logic [MEAN_W-1:0]         ground_level;

   altitude_reading_type      pending_readings [$];

   int                        sender_idle_pct = 30;
   int                        receiver_stall_pct = 80;
   int                        quiet_cycles = 0;
   int                        mismatches = 0;
   int                        samples_taken = 0;
   int                        readings_checked = 0;
   int                        captures_taken = 0;
   int                        percent_low = 0;
   int                        percent_high = 0;

   adc_window_average_altitude dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_capture_ground (req_capture_ground),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mean           (rsp_mean),
      .rsp_ground         (rsp_ground),
      .rsp_top            (rsp_top),
      .rsp_percent        (rsp_percent)
   );

   always #6 clock = ~clock;

   // advance the ring by one sample and work out the reading it gives
   task automatic altitude_step(input logic [SAMPLE_W-1:0] sample, input logic capture,
                                output altitude_reading_type reading);
      logic [SAMPLE_W-1:0] kept;
      int                  mean_i;
      int                  top_i;
      int                  pct_i;
      kept = sample & SAMPLE_MASK;
      ring_sum = ring_sum - int'(ring_samples[ring_pos]) + int'(kept);
      ring_samples[ring_pos] = kept;
      ring_pos = (ring_pos + 1 >= DEPTH) ? 0 : ring_pos + 1;
      // rounded mean, half counts round up
      mean_i = (2 * ring_sum + DEPTH) / (2 * DEPTH);
      if (capture)
         ground_level = mean_i[MEAN_W-1:0];
      top_i = int'(ground_level) - SPAN_COUNTS;
      // signed int division truncates toward zero
      pct_i = ((int'(ground_level) - (mean_i & FULL_SCALE)) * PCT_SCALE) / SPAN_COUNTS;
      if (pct_i > PCT_POS_LIM)
         pct_i = PCT_POS_LIM;
      if (pct_i < -PCT_NEG_LIM)
         pct_i = -PCT_NEG_LIM;
      reading.mean    = mean_i[MEAN_W-1:0];
      reading.ground  = ground_level;
      reading.top     = top_i[TOP_W-1:0];
      reading.percent = pct_i[PCT_W-1:0];
   endtask

   task automatic check_field(input string field, input int wanted, input int seen);
      if (wanted != seen) begin
         $display("%0t reading mismatch on %s: expected %0d, actual %0d",
                  $time, field, wanted, seen);
         mismatches++;
      end
   endtask

   // watches both channels at every edge: predicts on req beats, checks rsp beats
   always @(posedge clock) begin : reading_monitor
      altitude_reading_type predicted;
      altitude_reading_type wanted;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            altitude_step(req_sample, req_capture_ground, predicted);
            if (beat_fixed)
               pending_readings.push_back(beat_fixed_reading);
            else
               pending_readings.push_back(predicted);
            samples_taken++;
            if (req_capture_ground)
               captures_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_readings.size() == 0) begin
               $display("%0t unexpected reading: mean %0d ground %0d top %0d percent %0d",
                        $time, rsp_mean, rsp_ground, rsp_top, rsp_percent);
               mismatches++;
            end else begin
               wanted = pending_readings.pop_front();
               check_field("mean", int'(wanted.mean), int'(rsp_mean));
               check_field("ground", int'(wanted.ground), int'(rsp_ground));
               check_field("top", int'(wanted.top), int'(rsp_top));
               check_field("percent", int'(wanted.percent), int'(rsp_percent));
               readings_checked++;
               if (int'(rsp_percent) < percent_low)
                  percent_low = int'(rsp_percent);
               if (int'(rsp_percent) > percent_high)
                  percent_high = int'(rsp_percent);
            end
         end
      end
   end

   // receiver back-pressure at the rate of the current phase
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // give up once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t no beat moved for %0d cycles, %0d readings outstanding",
                  $time, QUIET_LIMIT, pending_readings.size());
         $display("FAIL adc_window_average_altitude");
         $finish;
      end
   end

   // present one sample beat, maybe after some idle cycles, and hold it until taken
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic capture,
                              input logic fixed, input altitude_reading_type reading);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sample         <= sample;
      req_capture_ground <= capture;
      beat_fixed         <= fixed;
      beat_fixed_reading <= reading;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // mostly steady levels long enough to fill the ring, with bursts of noise between
   task automatic send_random_samples(input int count);
      int left;
      int run_len;
      int level;
      int value;
      left = count;
      while (left > 0) begin
         if ($urandom_range(9) < 5) begin
            run_len = $urandom_range(45, 20);
            case ($urandom_range(3))
               0: level = 0;
               1: level = FULL_SCALE;
               default: level = $urandom_range(FULL_SCALE);
            endcase
         end else begin
            run_len = $urandom_range(20, 1);
            level = -1;
         end
         for (int k = 0; k < run_len && left > 0; k++) begin
            if (level < 0)
               value = $urandom_range(FULL_SCALE);
            else if (level == 0 || level == FULL_SCALE)
               value = level;
            else
               value = level + $urandom_range(6) - 3;
            if (value < 0)
               value = 0;
            if (value > FULL_SCALE)
               value = FULL_SCALE;
            send_sample(value[SAMPLE_W-1:0], ($urandom_range(7) == 0), 1'b0, '0);
            left--;
         end
      end
   endtask

   // sender goes quiet, then waits until every reading has come back
   task automatic drain_readings();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++)
         ring_samples[i] = '0;
      ring_pos = 0;
      ring_sum = 0;
      ground_level = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles lightly, receiver stalls heavily
      sender_idle_pct = 30;
      receiver_stall_pct = 80;
      foreach (directed_rows[r]) begin
         for (int n = 0; n < int'(directed_rows[r].repeats); n++)
            send_sample(directed_rows[r].sample, directed_rows[r].capture,
                        directed_rows[r].fixed, directed_rows[r].reading);
      end
      send_random_samples(500);

      // pause with the pipeline fully drained before the next phase
      drain_readings();

      // phase two: the other way round
      sender_idle_pct = 80;
      receiver_stall_pct = 30;
      send_random_samples(500);

      // phase three: back to back, no idling on either side
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_random_samples(524);

      drain_readings();
      // wait on past the drain to catch stray beats
      repeat (8) @(posedge clock);

      $display("%0d sample beats taken, %0d readings checked, %0d ground captures",
               samples_taken, readings_checked, captures_taken);
      $display("percent reached %0d to %0d, %0d mismatches", percent_low, percent_high,
               mismatches);
      if (mismatches == 0)
         $display("PASS adc_window_average_altitude");
      else
         $display("FAIL adc_window_average_altitude");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/awa_pkg.sv
rtl/core/awa_front.sv
rtl/core/awa_queue.sv
rtl/core/awa_back.sv
rtl/core/adc_window_average_altitude.sv
rtl/core/awa_checker.sv
bench/adc_window_average_altitude_tb.sv
